// File: rtl/ihq_pkg.sv
// Package with request codes, status codes, FSM states and defaults for the indexed min-heap queue.
package ihq_pkg;

  // Default sizes.
  localparam int unsigned MaxNodesDefault = 256;
  localparam int unsigned KeyWidthDefault = 32;

  // Node ids are eight bits wide, so at most this many nodes can be present.
  localparam int unsigned IdSpace = 256;
  localparam int unsigned IdWidth = 8;
  localparam int unsigned CountWidth = 9;

  // Request codes.
  localparam logic [1:0] ReqInsert   = 2'd0;
  localparam logic [1:0] ReqDecrease = 2'd1;
  localparam logic [1:0] ReqExtract  = 2'd2;

  // Status codes.
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StEmpty      = 3'd1;
  localparam logic [2:0] StPresent    = 3'd2;
  localparam logic [2:0] StNotPresent = 3'd3;
  localparam logic [2:0] StFull       = 3'd4;
  localparam logic [2:0] StNotSmaller = 3'd5;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_KEY,
    S_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } ihq_state_e;

endpackage

// File: rtl/indexed_min_heap_queue.sv
// Indexed binary min-heap with decrease-key, heap slots and position map in synchronous RAMs.
// Requests are handled one at a time; sift-up and sift-down move one level per pass, as the
// single heap RAM read port reads one slot at a time. A sift-up ends at the root or at a parent
// that is not larger; a sift-down ends at a leaf or when no child is smaller than the item.
// The next request is taken only once the result has entered the output register.
// Reset clears all present bits, the count and the output valid, and sets the limit to 256.
module indexed_min_heap_queue
  import ihq_pkg::*;
#(
  parameter int unsigned MAX_NODES = MaxNodesDefault,
  parameter int unsigned KEY_WIDTH = KeyWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Configuration: occupancy limit.
  input  logic                  cfg_we_i,
  input  logic [CountWidth-1:0] cfg_wdata_i,
  // Request items.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // req_type[1:0], node_id[9:2], key[KEY_WIDTH+9:10], zero fill above
  input  logic [((10+KEY_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // Result items.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // out_node_id[7:0], out_key, status (3 bits), count (9 bits), zero fill above
  output logic [((20+KEY_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);

  localparam int unsigned HeapDepth = (MAX_NODES < IdSpace) ? MAX_NODES : IdSpace;
  localparam int unsigned HIdxW     = $clog2(HeapDepth);
  localparam int unsigned EntryW    = IdWidth + KEY_WIDTH;
  localparam int unsigned OutW      = ((20 + KEY_WIDTH + 7) / 8) * 8;

  // Input fields.
  logic [1:0]           in_type;
  logic [IdWidth-1:0]   in_id;
  logic [KEY_WIDTH-1:0] in_key;
  assign in_type = s_axis_tdata[1:0];
  assign in_id   = s_axis_tdata[9:2];
  assign in_key  = s_axis_tdata[10+KEY_WIDTH-1:10];

  // Memories: heap slots hold {key, id}; the position map holds a slot per node id.
  logic [EntryW-1:0] heap_mem [HeapDepth];
  logic [HIdxW-1:0]  pos_mem  [IdSpace];
  logic [EntryW-1:0] heap_rd_q;
  logic [HIdxW-1:0]  pos_rd_q;
  logic              heap_we, pos_we;
  logic [HIdxW-1:0]  heap_raddr, heap_waddr, pos_wdata;
  logic [EntryW-1:0] heap_wdata;
  logic [IdWidth-1:0] pos_raddr, pos_waddr;

  // Control and data registers.
  ihq_state_e state_q, state_d;
  logic [1:0]            type_q, type_d;
  logic [IdWidth-1:0]    id_q, id_d;
  logic [KEY_WIDTH-1:0]  key_q, key_d;
  logic [IdWidth-1:0]    item_id_q, item_id_d;
  logic [KEY_WIDTH-1:0]  item_key_q, item_key_d;
  logic [HIdxW-1:0]      idx_q, idx_d;
  logic [EntryW-1:0]     left_q, left_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] nv_q;
  logic [IdSpace-1:0]    present_q, present_d;
  logic [IdWidth-1:0]    res_id_q, res_id_d;
  logic [KEY_WIDTH-1:0]  res_key_q, res_key_d;
  logic [2:0]            res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutW-1:0]       out_data_q, out_data_d;

  // Shared decode of the read data and the tree arithmetic.
  logic [IdWidth-1:0]    rd_id, left_id;
  logic [KEY_WIDTH-1:0]  rd_key, left_key, min_key;
  logic [HIdxW-1:0]      parent_idx;
  logic [9:0]            l_idx, r_idx, count_ext;
  logic                  l_ok, r_ok, sel_left, sel_right;
  logic [CountWidth-1:0] cap, last;
  logic                  full, accept, out_free;

  assign rd_id      = heap_rd_q[IdWidth-1:0];
  assign rd_key     = heap_rd_q[EntryW-1:IdWidth];
  assign left_id    = left_q[IdWidth-1:0];
  assign left_key   = left_q[EntryW-1:IdWidth];
  assign parent_idx = (idx_q - HIdxW'(1)) >> 1;
  assign l_idx      = 10'({idx_q, 1'b1});
  assign r_idx      = l_idx + 10'd1;
  assign count_ext  = {1'b0, count_q};
  assign l_ok       = l_idx < count_ext;
  assign r_ok       = r_idx < count_ext;
  assign sel_left   = left_key < item_key_q;
  assign min_key    = sel_left ? left_key : item_key_q;
  assign sel_right  = r_ok && (rd_key < min_key);
  assign cap        = (nv_q > CountWidth'(HeapDepth)) ? CountWidth'(HeapDepth) : nv_q;
  assign full       = count_q >= cap;
  assign last       = count_q - CountWidth'(1);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_POS;
      end
      S_POS: begin
        state_d = S_DONE;
        case (type_q)
          ReqInsert: begin
            if (present_q[id_q]) state_d = S_KEY;
            else if (!full) state_d = S_UP_RD;
          end
          ReqDecrease: begin
            if (present_q[id_q]) state_d = S_KEY;
          end
          ReqExtract: begin
            if (count_q > CountWidth'(1)) state_d = S_LAST;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_KEY: begin
        if (type_q == ReqDecrease && key_q < rd_key) state_d = S_UP_RD;
        else state_d = S_DONE;
      end
      S_LAST:   state_d = S_DN_RDL;
      S_UP_RD:  state_d = (idx_q == '0) ? S_PLACE : S_UP_CMP;
      S_UP_CMP: state_d = (rd_key <= item_key_q) ? S_PLACE : S_UP_RD;
      S_DN_RDL: state_d = l_ok ? S_DN_RDR : S_PLACE;
      S_DN_RDR: state_d = S_DN_CMP;
      S_DN_CMP: state_d = (sel_right || sel_left) ? S_DN_RDL : S_PLACE;
      S_PLACE:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    type_d      = type_q;
    id_d        = id_q;
    key_d       = key_q;
    item_id_d   = item_id_q;
    item_key_d  = item_key_q;
    idx_d       = idx_q;
    left_d      = left_q;
    count_d     = count_q;
    present_d   = present_q;
    res_id_d    = res_id_q;
    res_key_d   = res_key_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    heap_raddr  = '0;
    pos_raddr   = in_id;
    heap_we     = 1'b0;
    heap_waddr  = idx_q;
    heap_wdata  = {item_key_q, item_id_q};
    pos_we      = 1'b0;
    pos_waddr   = item_id_q;
    pos_wdata   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        // Latch the request; the root and the node's slot are read meanwhile.
        if (accept) begin
          type_d    = in_type;
          id_d      = in_id;
          key_d     = in_key;
          res_id_d  = in_id;
          res_key_d = '0;
          res_st_d  = StOk;
        end
      end
      S_POS: begin
        case (type_q)
          ReqInsert: begin
            if (present_q[id_q]) begin
              heap_raddr = pos_rd_q;
              res_st_d   = StPresent;
            end else if (full) begin
              res_st_d = StFull;
            end else begin
              present_d[id_q] = 1'b1;
              count_d    = count_q + CountWidth'(1);
              idx_d      = count_q[HIdxW-1:0];
              item_id_d  = id_q;
              item_key_d = key_q;
              res_key_d  = key_q;
            end
          end
          ReqDecrease: begin
            if (present_q[id_q]) begin
              heap_raddr = pos_rd_q;
              idx_d      = pos_rd_q;
            end else begin
              res_st_d = StNotPresent;
            end
          end
          ReqExtract: begin
            if (count_q == '0) begin
              res_st_d = StEmpty;
              res_id_d = '0;
            end else begin
              // The root leaves; the last slot refills it from the top.
              res_id_d  = rd_id;
              res_key_d = rd_key;
              present_d[rd_id] = 1'b0;
              count_d    = last;
              heap_raddr = last[HIdxW-1:0];
            end
          end
          default: ;
        endcase
      end
      S_KEY: begin
        if (type_q == ReqDecrease && key_q < rd_key) begin
          item_id_d  = id_q;
          item_key_d = key_q;
          res_key_d  = key_q;
        end else begin
          res_key_d = rd_key;
          if (type_q == ReqDecrease) res_st_d = StNotSmaller;
        end
      end
      S_LAST: begin
        item_id_d  = rd_id;
        item_key_d = rd_key;
        idx_d      = '0;
      end
      S_UP_RD: begin
        heap_raddr = parent_idx;
      end
      S_UP_CMP: begin
        // A strictly larger parent moves down into the hole.
        if (rd_key > item_key_q) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rd_q;
          pos_we     = 1'b1;
          pos_waddr  = rd_id;
          idx_d      = parent_idx;
        end
      end
      S_DN_RDL: begin
        heap_raddr = l_idx[HIdxW-1:0];
      end
      S_DN_RDR: begin
        left_d     = heap_rd_q;
        heap_raddr = r_idx[HIdxW-1:0];
      end
      S_DN_CMP: begin
        // The smaller child moves up into the hole; ties keep the left child.
        if (sel_right) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rd_q;
          pos_we     = 1'b1;
          pos_waddr  = rd_id;
          idx_d      = r_idx[HIdxW-1:0];
        end else if (sel_left) begin
          heap_we    = 1'b1;
          heap_wdata = left_q;
          pos_we     = 1'b1;
          pos_waddr  = left_id;
          idx_d      = l_idx[HIdxW-1:0];
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OutW'({count_q, res_st_q, res_key_q, res_id_q});
        end
      end
      default: ;
    endcase
  end

  // Heap slot RAM.
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    heap_rd_q <= heap_mem[heap_raddr];
  end

  // Position map RAM.
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_q <= pos_mem[pos_raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      present_q   <= '0;
      nv_q        <= CountWidth'(IdSpace);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) nv_q <= cfg_wdata_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    id_q       <= id_d;
    key_q      <= key_d;
    item_id_q  <= item_id_d;
    item_key_q <= item_key_d;
    idx_q      <= idx_d;
    left_q     <= left_d;
    res_id_q   <= res_id_d;
    res_key_q  <= res_key_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the indexed min-heap queue: stream stimulus, heap predictor, checks.
`timescale 1ns / 100ps

module tb_top
  import ihq_pkg::*;
();

  localparam int unsigned KW = KeyWidthDefault;
  localparam int unsigned SW = ((10 + KW + 7) / 8) * 8;
  localparam int unsigned MW = ((20 + KW + 7) / 8) * 8;
  localparam longint unsigned CycleLimit = 2000000;
  localparam logic [1:0] ReqReserved = 2'd3;

  typedef struct packed {
    logic [7:0]    node;
    logic [KW-1:0] key;
    logic [2:0]    status;
    logic [8:0]    count;
  } heap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CountWidth-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [SW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [MW-1:0] m_axis_tdata;

  indexed_min_heap_queue DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Predictor state: heap slots, per-node position map, count and limit.
  logic [7:0]    pm_ids [256];
  logic [KW-1:0] pm_keys [256];
  bit            pm_here [256];
  int unsigned   pm_pos [256];
  int unsigned   pm_count;
  int unsigned   pm_limit;

  heap_result_t  expected_results [$];
  int unsigned   errors = 0;
  longint unsigned cycles = 0;
  int unsigned   hold_cycles = 0;
  bit            rx_random = 1'b1;

  initial forever #2 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void heap_swap(int unsigned a, int unsigned b);
    logic [7:0] ti;
    logic [KW-1:0] tk;
    ti = pm_ids[a];
    tk = pm_keys[a];
    pm_ids[a] = pm_ids[b];
    pm_keys[a] = pm_keys[b];
    pm_ids[b] = ti;
    pm_keys[b] = tk;
    pm_pos[pm_ids[a]] = a;
    pm_pos[pm_ids[b]] = b;
  endfunction

  function automatic void heap_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (pm_keys[p] <= pm_keys[i]) break;
      heap_swap(p, i);
      i = p;
    end
  endfunction

  function automatic void heap_down(int unsigned i);
    int unsigned l, r, s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < pm_count && pm_keys[l] < pm_keys[s]) s = l;
      if (r < pm_count && pm_keys[r] < pm_keys[s]) s = r;
      if (s == i) break;
      heap_swap(i, s);
      i = s;
    end
  endfunction

  // Computes the result of one request and updates the predicted heap.
  function automatic heap_result_t heap_apply(logic [1:0] req, logic [7:0] id,
                                              logic [KW-1:0] key);
    heap_result_t r;
    int unsigned cap, i;
    r.node = id;
    r.key = '0;
    r.status = StOk;
    cap = (pm_limit > 256) ? 256 : pm_limit;
    case (req)
      ReqInsert: begin
        if (pm_here[id]) begin
          r.status = StPresent;
          r.key = pm_keys[pm_pos[id]];
        end else if (pm_count >= cap) begin
          r.status = StFull;
        end else begin
          i = pm_count;
          pm_ids[i] = id;
          pm_keys[i] = key;
          pm_here[id] = 1'b1;
          pm_pos[id] = i;
          pm_count = i + 1;
          heap_up(i);
          r.key = key;
        end
      end
      ReqDecrease: begin
        if (!pm_here[id]) begin
          r.status = StNotPresent;
        end else begin
          i = pm_pos[id];
          if (key >= pm_keys[i]) begin
            r.status = StNotSmaller;
            r.key = pm_keys[i];
          end else begin
            pm_keys[i] = key;
            heap_up(i);
            r.key = key;
          end
        end
      end
      ReqExtract: begin
        if (pm_count == 0) begin
          r.status = StEmpty;
          r.node = '0;
        end else begin
          r.node = pm_ids[0];
          r.key = pm_keys[0];
          pm_here[pm_ids[0]] = 1'b0;
          pm_count = pm_count - 1;
          if (pm_count > 0) begin
            pm_ids[0] = pm_ids[pm_count];
            pm_keys[0] = pm_keys[pm_count];
            pm_pos[pm_ids[0]] = 0;
            heap_down(0);
          end
        end
      end
      default: ;
    endcase
    r.count = pm_count[8:0];
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Sends one request item and records its expected result; valid stays high between
  // items sent without a gap.
  task automatic send_request(logic [1:0] req, logic [7:0] id, logic [KW-1:0] key,
                              bit gaps = 1'b1);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata <= {key, id, req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.insert(expected_results.size(), heap_apply(req, id, key));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    wait_drained();
    cfg_wdata_i <= v[8:0];
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pm_limit = v;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, always ready, or a long counted hold-off on request.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_random) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    heap_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.node = m_axis_tdata[7:0];
      got.key = m_axis_tdata[8 +: KW];
      got.status = m_axis_tdata[8+KW +: 3];
      got.count = m_axis_tdata[11+KW +: 9];
      if (expected_results.size() == 0) begin
        $error("result with no request pending: node %0d key %0h", got.node, got.key);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.node != want.node) begin
          $error("out_node_id: expected %0d, got %0d", want.node, got.node);
          errors++;
        end
        if (got.key != want.key) begin
          $error("out_key: expected %0h, got %0h", want.key, got.key);
          errors++;
        end
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.count != want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          errors++;
        end
      end
    end
  end

  // Corner cases at the reset limit: empty, reserved type, present, absent, not smaller.
  task automatic test_directed();
    send_request(ReqExtract, 8'hff, '1);
    send_request(ReqReserved, 8'haa, 32'h5555_5555);
    send_request(ReqDecrease, 8'd7, 32'd1);
    send_request(ReqInsert, 8'd0, '1);
    send_request(ReqInsert, 8'hff, '0);
    send_request(ReqInsert, 8'd0, 32'd4);
    send_request(ReqInsert, 8'h55, 32'd100);
    send_request(ReqInsert, 8'haa, 32'd100);
    send_request(ReqDecrease, 8'h55, 32'd100);
    send_request(ReqDecrease, 8'h55, 32'd200);
    send_request(ReqDecrease, 8'd0, 32'd100);
    send_request(ReqDecrease, 8'haa, 32'd0);
    send_request(ReqInsert, 8'd3, 32'd0);
    repeat (6) send_request(ReqExtract, 8'd0, '0);
    send_request(ReqReserved, 8'h55, '1);
  endtask

  // Limits of one and zero: full reports, then the largest limit.
  task automatic test_limits();
    write_limit(1);
    send_request(ReqInsert, 8'd9, 32'd5);
    send_request(ReqInsert, 8'd10, 32'd6);
    send_request(ReqExtract, 8'd0, '0);
    write_limit(0);
    send_request(ReqInsert, 8'd1, 32'd1);
    write_limit(511);
    send_request(ReqInsert, 8'd1, 32'd1);
    send_request(ReqExtract, 8'd0, '0);
  endtask

  // Fills all 256 ids with the receiver held off, then drains the heap.
  task automatic test_fill_and_drain();
    int unsigned k;
    write_limit(256);
    hold_cycles = 400;
    for (k = 0; k < 256; k++)
      send_request(ReqInsert, k[7:0], $urandom_range(0, 40), 1'b0);
    send_request(ReqInsert, 8'd0, 32'd1, 1'b0);
    wait_drained();
    for (k = 0; k < 257; k++) send_request(ReqExtract, k[7:0], '0);
  endtask

  // Prim-style random traffic under several limits, keys often tied.
  task automatic test_random(int unsigned n, int unsigned lim);
    int unsigned k, p;
    logic [7:0] id;
    logic [KW-1:0] key;
    logic [1:0] req;
    write_limit(lim);
    for (k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      req = (p < 40) ? ReqInsert : (p < 70) ? ReqDecrease :
            (p < 97) ? ReqExtract : ReqReserved;
      id = 8'((k % 2) ? $urandom_range(0, 31) : $urandom);
      key = KW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 63));
      send_request(req, id, key);
      if (k == n / 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      pm_here[i] = 1'b0;
      pm_pos[i] = 0;
    end
    pm_count = 0;
    pm_limit = 256;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_fill_and_drain();
    test_random(350, 256);
    test_random(200, 12);
    rx_random = 1'b0;
    test_random(250, 256);
    rx_random = 1'b1;
    test_random(100, 3);
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ihq_pkg.sv
rtl/indexed_min_heap_queue.sv
tb/tb_top.sv
